FILE: hdl/llh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llh_pkg
// Shared widths, field offsets and the sequencer state type of the
// log-linear latency histogram.
// ----------------------------------------------------------------------------
package llh_pkg;

  localparam int LAT_W  = 48;
  localparam int FRAC_W = 17;
  localparam int Q16_W  = 16;
  localparam int SUM_W  = 64;
  localparam int PROD_W = 64;

  localparam logic [Q16_W-1:0] Q16_ROUND = '1;

  // input tdata: latency, fraction_q16, zero pad to bytes
  localparam int IN_TDATA_W = 72;
  localparam int IN_LAT_LO  = 0;
  localparam int IN_FRAC_LO = 48;

  // output tdata: percentile, min, max, count, sum
  localparam int OUT_TDATA_W = 256;
  localparam int OUT_PCT_LO  = 0;
  localparam int OUT_MIN_LO  = 48;
  localparam int OUT_MAX_LO  = 96;
  localparam int OUT_CNT_LO  = 144;
  localparam int OUT_SUM_LO  = 192;

  // tuser code
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef enum logic [11:0] {
    ST_CLR     = 12'b0000_0000_0001,
    ST_IDLE    = 12'b0000_0000_0010,
    ST_R_SUM   = 12'b0000_0000_0100,
    ST_R_CNT   = 12'b0000_0000_1000,
    ST_R_NORM  = 12'b0000_0001_0000,
    ST_R_RD    = 12'b0000_0010_0000,
    ST_R_INC   = 12'b0000_0100_0000,
    ST_Q_START = 12'b0000_1000_0000,
    ST_Q_MUL   = 12'b0001_0000_0000,
    ST_Q_RD    = 12'b0010_0000_0000,
    ST_Q_ACC   = 12'b0100_0000_0000,
    ST_FIN     = 12'b1000_0000_0000
  } state_t;

endpackage

FILE: hdl/llh_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llh_norm
// Iterative bucket index finder: clamps a sample, then shifts it left one
// bit a cycle until the leading one reaches the top, counting the octave.
// ----------------------------------------------------------------------------
module llh_norm #(
  parameter int MAX_EXPONENT    = 32,
  parameter int SUB_BUCKET_BITS = 4,
  parameter int IW              = 9
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [llh_pkg::LAT_W-1:0] latency,
  output logic                     done,
  output logic [IW-1:0]            idx
);

  localparam int SW = MAX_EXPONENT + SUB_BUCKET_BITS;
  localparam int EW = $clog2(MAX_EXPONENT);
  localparam logic [llh_pkg::LAT_W-1:0] LAT_HI =
    llh_pkg::LAT_W'((64'd1 << MAX_EXPONENT) - 64'd1);

  logic                      busy;
  logic [SW-1:0]             sh;
  logic [EW-1:0]             octave;
  logic [llh_pkg::LAT_W-1:0] clamped;
  logic [IW-1:0]             sub;

  always_comb begin
    if (latency == '0) begin
      clamped = llh_pkg::LAT_W'(1);
    end else if (latency > LAT_HI) begin
      clamped = LAT_HI;
    end else begin
      clamped = latency;
    end
  end

  assign done = busy & sh[SW-1];
  // bits just below the leading one
  assign sub  = IW'(sh[SW-2:0] >> (MAX_EXPONENT - 1));
  assign idx  = (IW'(octave) << SUB_BUCKET_BITS) | sub;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh     <= SW'(clamped[MAX_EXPONENT-1:0]) << SUB_BUCKET_BITS;
      octave <= EW'(MAX_EXPONENT - 1);
    end else if (busy && !sh[SW-1]) begin
      sh     <= sh << 1;
      octave <= octave - EW'(1);
    end
  end

endmodule

FILE: hdl/llh_bucket_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llh_bucket_ram
// Bucket counter memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module llh_bucket_ram #(
  parameter int DEPTH = 512,
  parameter int AW    = 9,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/log_linear_latency_histogram.sv
`timescale 1ns / 1ps
// Record: sum, count, index search one bit a cycle, bucket read and increment,
//   finish; one item at a time, output backpressure can stall the finish state.
// Query: straight to finish for the empty, zero and full-fraction cases; otherwise
//   up to 16 multiply steps on the shared adder, then read and add per bucket walked.
// Reset: synchronous; a clearing pass then zeroes all MAX_EXPONENT << SUB_BUCKET_BITS
//   buckets, one per cycle, before the first transaction is accepted.
// ----------------------------------------------------------------------------
// log_linear_latency_histogram
// Log-linear latency histogram with percentile query, built around one
// shared 64-bit adder under a small sequencer.
// ----------------------------------------------------------------------------
module log_linear_latency_histogram #(
  parameter int MAX_EXPONENT        = 32,
  parameter int SUB_BUCKET_BITS     = 4,
  parameter int BUCKET_COUNTER_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [llh_pkg::IN_TDATA_W-1:0]      s_tdata,  // latency, fraction_q16, pad
  input  logic                                s_tuser,  // mode
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [llh_pkg::OUT_TDATA_W-1:0]     m_tdata   // percentile_value, min_latency,
                                                        // max_latency, total_samples,
                                                        // latency_total
);

  localparam int BUCKET_TOTAL = MAX_EXPONENT << SUB_BUCKET_BITS;
  localparam int IW           = $clog2(BUCKET_TOTAL);
  localparam int CW           = BUCKET_COUNTER_BITS;
  localparam int LW           = llh_pkg::LAT_W;
  localparam int SUMW         = llh_pkg::SUM_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(BUCKET_TOTAL - 1);
  localparam logic [63:0]   SUB_MASK = (64'd1 << SUB_BUCKET_BITS) - 64'd1;

  llh_pkg::state_t state;

  // captured transaction
  logic                          mode_r;
  logic [LW-1:0]                 lat_r;
  logic [llh_pkg::FRAC_W-1:0]    frac_r;

  // statistics
  logic [LW-1:0]   min_seen;
  logic [LW-1:0]   max_seen;
  logic [LW-1:0]   sample_count;
  logic [SUMW-1:0] running_sum;

  // query datapath
  logic [llh_pkg::PROD_W-1:0] prod;
  logic [llh_pkg::PROD_W-1:0] mcand;
  logic [llh_pkg::Q16_W-1:0]  mplier;
  logic [LW-1:0]              target;
  logic [SUMW-1:0]            acc;
  logic [IW-1:0]              walk_idx;
  logic [LW-1:0]              answer;

  logic [IW-1:0] clr_idx;
  logic [IW-1:0] idx_r;

  // shared adder
  logic [SUMW-1:0] add_a;
  logic [SUMW-1:0] add_b;
  logic [SUMW:0]   add_res;
  logic [SUMW-1:0] acc_next;

  logic          norm_start;
  logic          norm_done;
  logic [IW-1:0] norm_idx;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [CW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [CW-1:0] ram_rdata;

  logic [63:0] lb_mant;
  logic [5:0]  lb_shift;
  logic [63:0] lb_full;
  logic        out_free;

  always_comb begin
    case (state)
      llh_pkg::ST_R_SUM: begin
        add_a = running_sum;
        add_b = SUMW'(lat_r);
      end
      llh_pkg::ST_R_CNT: begin
        add_a = SUMW'(sample_count);
        add_b = SUMW'(1);
      end
      llh_pkg::ST_R_INC: begin
        add_a = SUMW'(ram_rdata);
        add_b = SUMW'(1);
      end
      llh_pkg::ST_Q_MUL: begin
        add_a = prod;
        add_b = mcand;
      end
      llh_pkg::ST_Q_ACC: begin
        add_a = acc;
        add_b = SUMW'(ram_rdata);
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign add_res  = {1'b0, add_a} + {1'b0, add_b};
  // cumulative count saturates
  assign acc_next = add_res[SUMW] ? '1 : add_res[SUMW-1:0];

  // bucket lower bound: ((2^S + sub) << octave) >> S
  assign lb_mant  = (64'(walk_idx) & SUB_MASK) | (64'd1 << SUB_BUCKET_BITS);
  assign lb_shift = 6'(64'(walk_idx) >> SUB_BUCKET_BITS);
  assign lb_full  = (lb_mant << lb_shift) >> SUB_BUCKET_BITS;

  assign norm_start = (state == llh_pkg::ST_R_CNT);

  llh_norm #(
    .MAX_EXPONENT   (MAX_EXPONENT),
    .SUB_BUCKET_BITS(SUB_BUCKET_BITS),
    .IW             (IW)
  ) u_norm (
    .clk    (clk),
    .rst    (rst),
    .start  (norm_start),
    .latency(lat_r),
    .done   (norm_done),
    .idx    (norm_idx)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = CW'(add_res);
    if (state == llh_pkg::ST_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = '0;
    end else if (state == llh_pkg::ST_R_INC) begin
      ram_we    = ~(&ram_rdata);
    end
  end

  assign ram_raddr = (state == llh_pkg::ST_R_RD) ? idx_r : walk_idx;

  llh_bucket_ram #(
    .DEPTH(BUCKET_TOTAL),
    .AW   (IW),
    .DW   (CW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign s_tready = (state == llh_pkg::ST_IDLE);
  assign out_free = ~m_tvalid | m_tready;

  // output valid: loaded from the finish state, dropped once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == llh_pkg::ST_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= llh_pkg::ST_CLR;
      clr_idx      <= '0;
      min_seen     <= '0;
      max_seen     <= '0;
      sample_count <= '0;
      running_sum  <= '0;
    end else begin
      case (state)
        llh_pkg::ST_CLR: begin
          clr_idx <= clr_idx + IW'(1);
          if (clr_idx == LAST_IDX) begin
            state <= llh_pkg::ST_IDLE;
          end
        end
        llh_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            state <= (s_tuser == llh_pkg::MODE_QUERY) ? llh_pkg::ST_Q_START
                                                      : llh_pkg::ST_R_SUM;
          end
        end
        llh_pkg::ST_R_SUM: begin
          running_sum <= add_res[SUMW-1:0];
          if (sample_count == '0 || lat_r < min_seen) begin
            min_seen <= lat_r;
          end
          if (sample_count == '0 || lat_r > max_seen) begin
            max_seen <= lat_r;
          end
          state <= llh_pkg::ST_R_CNT;
        end
        llh_pkg::ST_R_CNT: begin
          if (sample_count != '1) begin
            sample_count <= add_res[LW-1:0];
          end
          state <= llh_pkg::ST_R_NORM;
        end
        llh_pkg::ST_R_NORM: begin
          if (norm_done) begin
            state <= llh_pkg::ST_R_RD;
          end
        end
        llh_pkg::ST_R_RD: begin
          state <= llh_pkg::ST_R_INC;
        end
        llh_pkg::ST_R_INC: begin
          state <= llh_pkg::ST_FIN;
        end
        llh_pkg::ST_Q_START: begin
          if (sample_count == '0 || frac_r == '0 || frac_r[llh_pkg::Q16_W]) begin
            state <= llh_pkg::ST_FIN;
          end else begin
            state <= llh_pkg::ST_Q_MUL;
          end
        end
        llh_pkg::ST_Q_MUL: begin
          if (mplier == '0) begin
            state <= llh_pkg::ST_Q_RD;
          end
        end
        llh_pkg::ST_Q_RD: begin
          state <= llh_pkg::ST_Q_ACC;
        end
        llh_pkg::ST_Q_ACC: begin
          if (acc_next >= SUMW'(target) || walk_idx == LAST_IDX) begin
            state <= llh_pkg::ST_FIN;
          end else begin
            state <= llh_pkg::ST_Q_RD;
          end
        end
        llh_pkg::ST_FIN: begin
          if (out_free) begin
            state <= llh_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= llh_pkg::ST_CLR;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      llh_pkg::ST_IDLE: begin
        mode_r <= s_tuser;
        lat_r  <= s_tdata[llh_pkg::IN_LAT_LO +: LW];
        frac_r <= s_tdata[llh_pkg::IN_FRAC_LO +: llh_pkg::FRAC_W];
        answer <= '0;
      end
      llh_pkg::ST_R_NORM: begin
        idx_r <= norm_idx;
      end
      llh_pkg::ST_Q_START: begin
        if (sample_count == '0) begin
          answer <= '0;
        end else if (frac_r == '0) begin
          answer <= min_seen;
        end else if (frac_r[llh_pkg::Q16_W]) begin
          answer <= max_seen;
        end
        // ceil(p * count / 2^16) by shift and add
        prod     <= llh_pkg::PROD_W'(llh_pkg::Q16_ROUND);
        mcand    <= llh_pkg::PROD_W'(sample_count);
        mplier   <= frac_r[llh_pkg::Q16_W-1:0];
      end
      llh_pkg::ST_Q_MUL: begin
        if (mplier == '0) begin
          target   <= prod[llh_pkg::PROD_W-1 -: LW];
          acc      <= '0;
          walk_idx <= '0;
        end else begin
          if (mplier[0]) begin
            prod <= add_res[llh_pkg::PROD_W-1:0];
          end
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
        end
      end
      llh_pkg::ST_Q_ACC: begin
        acc <= acc_next;
        if (acc_next >= SUMW'(target)) begin
          answer <= lb_full[LW-1:0];
        end else if (walk_idx == LAST_IDX) begin
          answer <= max_seen;
        end else begin
          walk_idx <= walk_idx + IW'(1);
        end
      end
      llh_pkg::ST_FIN: begin
        if (out_free) begin
          m_tdata <= {running_sum, sample_count, max_seen, min_seen,
                      (mode_r == llh_pkg::MODE_RECORD) ? LW'(0) : answer};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hdl/llh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llh_checker
// Port-level checks of the latency histogram, bound to the top level.
// ----------------------------------------------------------------------------
module llh_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [llh_pkg::IN_TDATA_W-1:0]  s_tdata,
  input logic                            s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [llh_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic [llh_pkg::LAT_W-1:0] pct;
  logic [llh_pkg::LAT_W-1:0] min_l;
  logic [llh_pkg::LAT_W-1:0] max_l;
  logic [llh_pkg::LAT_W-1:0] cnt;
  logic [llh_pkg::SUM_W-1:0] sum;

  assign pct   = m_tdata[llh_pkg::OUT_PCT_LO +: llh_pkg::LAT_W];
  assign min_l = m_tdata[llh_pkg::OUT_MIN_LO +: llh_pkg::LAT_W];
  assign max_l = m_tdata[llh_pkg::OUT_MAX_LO +: llh_pkg::LAT_W];
  assign cnt   = m_tdata[llh_pkg::OUT_CNT_LO +: llh_pkg::LAT_W];
  assign sum   = m_tdata[llh_pkg::OUT_SUM_LO +: llh_pkg::SUM_W];

  // a stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output transaction changed while stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while previous item in work");

  // empty histogram reports zeros everywhere
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && cnt == '0 |-> pct == '0 && min_l == '0 && max_l == '0 && sum == '0)
    else $error("nonzero statistics with no samples");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && cnt != '0 |-> min_l <= max_l)
    else $error("minimum above maximum");

endmodule

bind log_linear_latency_histogram llh_checker u_llh_checker (.*);

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the log-linear latency histogram. Record and
// query transactions go in on the slave stream, and a local model of the
// buckets and running statistics predicts every result word. Each result
// is checked field by field against the oldest prediction. Directed edge
// cases come first, then random traffic under three backpressure patterns.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_EXP      = 32;
  localparam int SUB_BITS     = 4;
  localparam int CNT_BITS     = 32;
  localparam int NUM_BINS     = MAX_EXP << SUB_BITS;
  localparam int DRAIN_CYCLES = 2 * NUM_BINS + 64;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int REPORT_MAX   = 10;

  localparam logic [llh_pkg::FRAC_W-1:0] FRAC_ONE = 17'h10000;
  localparam logic [llh_pkg::LAT_W-1:0]  LAT_MAX  = '1;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [llh_pkg::IN_TDATA_W-1:0]  s_tdata = '0;   // latency, fraction_q16, pad
  logic                            s_tuser = llh_pkg::MODE_RECORD;  // mode
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [llh_pkg::OUT_TDATA_W-1:0] m_tdata;  // percentile_value, min_latency,
                                             // max_latency, total_samples,
                                             // latency_total

  // model of the histogram
  logic [CNT_BITS-1:0]           hist_bins [NUM_BINS];
  logic [llh_pkg::LAT_W-1:0]     seen_count;
  logic [llh_pkg::LAT_W-1:0]     seen_min;
  logic [llh_pkg::LAT_W-1:0]     seen_max;
  logic [llh_pkg::SUM_W-1:0]     seen_sum;

  logic [llh_pkg::OUT_TDATA_W-1:0] expected_stats [$];

  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    error_count   = 0;
  int    report_count  = 0;
  int    cycle_count   = 0;
  string field_names [5] = '{"percentile_value", "min_latency", "max_latency",
                             "total_samples", "latency_total"};

  log_linear_latency_histogram #(
    .MAX_EXPONENT        (MAX_EXP),
    .SUB_BUCKET_BITS     (SUB_BITS),
    .BUCKET_COUNTER_BITS (CNT_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int bin_of(logic [llh_pkg::LAT_W-1:0] v);
    logic [63:0] c;
    logic [63:0] sub;
    int          e;
    int          i;
    int          idx;
    c = 64'(v);
    if (c < 64'd1) c = 64'd1;
    if (c > (64'd1 << MAX_EXP) - 64'd1) c = (64'd1 << MAX_EXP) - 64'd1;
    e = 0;
    for (i = 0; i < 64; i++)
      if (c[i]) e = i;
    sub = ((c - (64'd1 << e)) << SUB_BITS) >> e;
    idx = (e << SUB_BITS) + int'(sub);
    return (idx < NUM_BINS) ? idx : NUM_BINS - 1;
  endfunction

  function automatic logic [llh_pkg::LAT_W-1:0] bin_floor(int idx);
    logic [63:0] base;
    logic [63:0] sub;
    base = 64'd1 << ((idx >> SUB_BITS) & 63);
    sub  = 64'(idx & ((1 << SUB_BITS) - 1));
    return llh_pkg::LAT_W'(base + ((base * sub) >> SUB_BITS));
  endfunction

  function automatic logic [llh_pkg::LAT_W-1:0] answer_percentile(
    logic [llh_pkg::FRAC_W-1:0] frac);
    logic [63:0] goal;
    logic [63:0] acc;
    int          b;
    if (seen_count == '0) return '0;
    if (frac == '0) return seen_min;
    if (frac >= FRAC_ONE) return seen_max;
    goal = (64'(frac) * 64'(seen_count) + 64'(llh_pkg::Q16_ROUND)) >> llh_pkg::Q16_W;
    if (goal < 64'd1) goal = 64'd1;
    acc = '0;
    for (b = 0; b < NUM_BINS; b++) begin
      acc = (acc > ~64'd0 - 64'(hist_bins[b])) ? ~64'd0 : acc + 64'(hist_bins[b]);
      if (acc >= goal) return bin_floor(b);
    end
    return seen_max;
  endfunction

  function automatic logic [llh_pkg::OUT_TDATA_W-1:0] update_stats(
    logic mode, logic [llh_pkg::LAT_W-1:0] lat, logic [llh_pkg::FRAC_W-1:0] frac);
    logic [llh_pkg::LAT_W-1:0] answer;
    int                        idx;
    answer = '0;
    if (mode == llh_pkg::MODE_RECORD) begin
      if (seen_count == '0 || lat < seen_min) seen_min = lat;
      if (seen_count == '0 || lat > seen_max) seen_max = lat;
      seen_sum = seen_sum + 64'(lat);
      if (seen_count != '1) seen_count = seen_count + 1'b1;
      idx = bin_of(lat);
      if (hist_bins[idx] != '1) hist_bins[idx] = hist_bins[idx] + 1'b1;
    end else begin
      answer = answer_percentile(frac);
    end
    return {seen_sum, seen_count, seen_max, seen_min, answer};
  endfunction

  task automatic compare_result(logic [llh_pkg::OUT_TDATA_W-1:0] got);
    logic [llh_pkg::OUT_TDATA_W-1:0] want;
    logic [63:0]                     mask;
    logic [63:0]                     want_f;
    logic [63:0]                     got_f;
    int                              f;
    int                              lo;
    if (expected_stats.size() == 0) begin
      error_count++;
      if (report_count < REPORT_MAX)
        $display("result with nothing pending: %0h", got);
      report_count++;
      return;
    end
    want = expected_stats.pop_front();
    for (f = 0; f < 5; f++) begin
      lo     = llh_pkg::OUT_PCT_LO + f * llh_pkg::LAT_W;
      mask   = (f == 4) ? ~64'd0 : (64'd1 << llh_pkg::LAT_W) - 64'd1;
      want_f = 64'(want >> lo) & mask;
      got_f  = 64'(got >> lo) & mask;
      if (want_f !== got_f) begin
        error_count++;
        if (report_count < REPORT_MAX)
          $display("mismatch %s: expected %0h, got %0h", field_names[f], want_f, got_f);
        report_count++;
      end
    end
  endtask

  // result side: check accepted transactions, then pick next ready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) compare_result(m_tdata);
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(logic mode, logic [llh_pkg::LAT_W-1:0] lat,
                           logic [llh_pkg::FRAC_W-1:0] frac);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= llh_pkg::IN_TDATA_W'({frac, lat});
    expected_stats.push_back(update_stats(mode, lat, frac));
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [llh_pkg::LAT_W-1:0] rand_latency();
    logic [llh_pkg::LAT_W-1:0] full;
    full = llh_pkg::LAT_W'({$urandom, $urandom});
    case ($urandom_range(9))
      0:       return full;
      1:       return llh_pkg::LAT_W'($urandom_range(2));
      2:       return llh_pkg::LAT_W'(full | (llh_pkg::LAT_W'(1) << MAX_EXP));
      default: return full >> $urandom_range(llh_pkg::LAT_W - 1, llh_pkg::LAT_W - MAX_EXP);
    endcase
  endfunction

  function automatic logic [llh_pkg::FRAC_W-1:0] rand_fraction();
    case ($urandom_range(9))
      0:       return '0;
      1:       return llh_pkg::FRAC_W'($urandom_range(131071, 65536));
      default: return llh_pkg::FRAC_W'($urandom_range(65535, 1));
    endcase
  endfunction

  task automatic test_empty_queries();
    send_item(llh_pkg::MODE_QUERY, '0, '0);
    send_item(llh_pkg::MODE_QUERY, LAT_MAX, 17'd32768);
    send_item(llh_pkg::MODE_QUERY, '0, FRAC_ONE);
    send_item(llh_pkg::MODE_QUERY, '0, '1);
  endtask

  // zero, tiny, octave edges and values beyond the last bucket
  task automatic test_extreme_records();
    send_item(llh_pkg::MODE_RECORD, '0, '1);
    send_item(llh_pkg::MODE_RECORD, 48'd1, '0);
    send_item(llh_pkg::MODE_RECORD, 48'd2, '0);
    send_item(llh_pkg::MODE_RECORD, 48'd3, '0);
    send_item(llh_pkg::MODE_RECORD, 48'd12345, '0);
    send_item(llh_pkg::MODE_RECORD, (48'd1 << MAX_EXP) - 48'd1, '0);
    send_item(llh_pkg::MODE_RECORD, 48'd1 << MAX_EXP, '0);
    send_item(llh_pkg::MODE_RECORD, LAT_MAX, '0);
  endtask

  task automatic test_percentile_edges();
    send_item(llh_pkg::MODE_QUERY, '0, '0);
    send_item(llh_pkg::MODE_QUERY, '0, 17'd1);
    send_item(llh_pkg::MODE_QUERY, '0, 17'd16384);
    send_item(llh_pkg::MODE_QUERY, '0, 17'd32768);
    send_item(llh_pkg::MODE_QUERY, '0, 17'd65535);
    send_item(llh_pkg::MODE_QUERY, '0, FRAC_ONE);
    send_item(llh_pkg::MODE_QUERY, LAT_MAX, '1);
    send_item(llh_pkg::MODE_RECORD, 48'd100, 17'd40000);
    send_item(llh_pkg::MODE_QUERY, 48'd77, 17'd40000);
  endtask

  task automatic test_random_traffic(int n, int send_pct, int recv_pct);
    int i;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(99) < 70)
        send_item(llh_pkg::MODE_RECORD, rand_latency(), llh_pkg::FRAC_W'($urandom));
      else
        send_item(llh_pkg::MODE_QUERY, llh_pkg::LAT_W'({$urandom, $urandom}),
                  rand_fraction());
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < NUM_BINS; i++) hist_bins[i] = '0;
    seen_count = '0;
    seen_min   = '0;
    seen_max   = '0;
    seen_sum   = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 57;
    test_empty_queries();
    test_extreme_records();
    test_percentile_edges();
    test_random_traffic(180, 36, 57);
    test_random_traffic(180, 57, 36);
    test_random_traffic(190, 0, 0);
    s_tvalid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_stats.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
